FILE: src/length_prefixed_param_parser_top_defines.svh
// Assertion macros used by the parser RTL.
`ifndef LENGTH_PREFIXED_PARAM_PARSER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_PARAM_PARSER_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LPP_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LPP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/lpp_pkg.sv
`default_nettype none

package lpp_pkg;

   localparam int BufferBytes = 65536;
   localparam int MaxParams   = 255;
   localparam int OffsetCap   = (BufferBytes - 1 < 65535) ? BufferBytes - 1 : 65535;
   localparam logic [15:0] OffsetCapW = 16'(OffsetCap);

   localparam int QueueDepth  = 4;
   localparam int QueueAddrW  = $clog2(QueueDepth);
   localparam int QueueCountW = $clog2(QueueDepth + 1);

   // Summary status codes
   localparam logic [1:0] StatusComplete  = 2'd0;
   localparam logic [1:0] StatusCountShort = 2'd1;
   localparam logic [1:0] StatusMismatch  = 2'd2;
   localparam logic [1:0] StatusTruncated = 2'd3;

   typedef struct packed {
      logic        is_summary;
      logic        final_res;
      logic [7:0]  param_index;
      logic [15:0] payload_offset;
      logic [31:0] declared_length;
      logic [15:0] available_length;
      logic [7:0]  params_read;
      logic [15:0] bytes_consumed;
      logic [1:0]  status;
      logic        ok;
   } lpp_result_type;

   typedef struct packed {
      logic           valid;
      lpp_result_type data;
   } lpp_push_type;

endpackage

`default_nettype wire

FILE: src/length_prefixed_param_parser_top.sv
`default_nettype none

// Channel   Dir  Handshake           Payload
// req_      in   req_valid/req_stall  data_byte, first_byte, last_byte
// rsp_      out  rsp_valid/rsp_stall  record or summary fields
// csr_      in   csr_valid/csr_ready  expected_count (8 bit)
//
// One request per cycle sustained while the queue has room; a request is
// parsed once it sits in the input register, its results land in a 4-entry queue.
// A request with a record and a summary needs two queue slots; the queue
// drains one result per cycle while rsp_stall is low.
// A request passes the input register, then the result queue, before its first result reaches rsp_.
// Synchronous active-high reset clears parse state, queue and expected_count.
// rsp_stall backs up into the queue, then the input register, then req_stall.
module length_prefixed_param_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_is_summary,
   output logic             rsp_final_res,
   output logic [7:0]       rsp_param_index,
   output logic [15:0]      rsp_payload_offset,
   output logic [31:0]      rsp_declared_length,
   output logic [15:0]      rsp_available_length,
   output logic [7:0]       rsp_params_read,
   output logic [15:0]      rsp_bytes_consumed,
   output logic [1:0]       rsp_status,
   output logic             rsp_ok,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_expected_count
);

   // Input register: holds one request until the core can take it.
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_last_ff;
   logic [7:0] exp_count_ff;

   logic       room;
   logic       step;
   logic       accept;

   lpp_pkg::lpp_push_type   push_a, push_b;
   lpp_pkg::lpp_result_type head;

   // The core consumes the held request only when the queue can take two.
   assign step      = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !step);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         exp_count_ff <= 8'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_valid && csr_ready) begin
            exp_count_ff <= csr_expected_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
         in_last_ff  <= req_last_byte;
      end
   end

   lpp_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .data_byte      (in_byte_ff),
      .first_byte     (in_first_ff),
      .last_byte      (in_last_ff),
      .expected_count (exp_count_ff),
      .push_a         (push_a),
      .push_b         (push_b)
   );

   lpp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_a    (push_a),
      .push_b    (push_b),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   assign rsp_is_summary       = head.is_summary;
   assign rsp_final_res        = head.final_res;
   assign rsp_param_index      = head.param_index;
   assign rsp_payload_offset   = head.payload_offset;
   assign rsp_declared_length  = head.declared_length;
   assign rsp_available_length = head.available_length;
   assign rsp_params_read      = head.params_read;
   assign rsp_bytes_consumed   = head.bytes_consumed;
   assign rsp_status           = head.status;
   assign rsp_ok               = head.ok;

endmodule

`default_nettype wire

FILE: src/lpp_core.sv
`default_nettype none

// Parse state and per-byte update. Produces up to two results per byte:
// push_a carries the first, push_b the second (only when push_a is used).
module lpp_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 first_byte,
   input  wire logic                 last_byte,
   input  wire logic [7:0]           expected_count,
   output lpp_pkg::lpp_push_type     push_a,
   output lpp_pkg::lpp_push_type     push_b
);

   typedef enum logic [1:0] {
      PhCount,
      PhLen,
      PhPayload,
      PhDone
   } phase_type;

   phase_type   phase_ff, phase_in, phase_e;
   logic [1:0]  wpos_ff, wpos_in, wpos_e;
   logic [23:0] wbytes_ff, wbytes_in, wbytes_e;
   logic [7:0]  pdone_ff, pdone_in, pdone_e;
   logic [31:0] left_ff, left_in, left_e;
   logic [31:0] curlen_ff, curlen_in, curlen_e;
   logic [15:0] pstart_ff, pstart_in, pstart_e;
   logic [15:0] offset_ff, offset_in, offset_e;
   logic [15:0] mark_ff, mark_in, mark_e;
   logic [1:0]  pstat_ff, pstat_in, pstat_e;

   logic [15:0] nxt;
   logic [31:0] word;
   logic        rec_vld;
   logic [31:0] rec_avail;
   logic [1:0]  sum_status;
   logic        sum_ok;
   logic        count_bad;
   lpp_pkg::lpp_result_type rec, sum;

   assign count_bad = ({24'd0, expected_count} > 32'(lpp_pkg::MaxParams));

   always_comb begin
      // first byte of a buffer restarts from a clean state
      phase_e  = first_byte ? PhCount : phase_ff;
      wpos_e   = first_byte ? 2'd0    : wpos_ff;
      wbytes_e = first_byte ? 24'd0   : wbytes_ff;
      pdone_e  = first_byte ? 8'd0    : pdone_ff;
      left_e   = first_byte ? 32'd0   : left_ff;
      curlen_e = first_byte ? 32'd0   : curlen_ff;
      pstart_e = first_byte ? 16'd0   : pstart_ff;
      offset_e = first_byte ? 16'd0   : offset_ff;
      mark_e   = first_byte ? 16'd0   : mark_ff;
      pstat_e  = first_byte ? 2'd0    : pstat_ff;

      nxt  = (offset_e < lpp_pkg::OffsetCapW) ? offset_e + 16'd1 : lpp_pkg::OffsetCapW;
      word = {data_byte, wbytes_e};

      phase_in  = phase_e;
      wpos_in   = wpos_e;
      wbytes_in = wbytes_e;
      pdone_in  = pdone_e;
      left_in   = left_e;
      curlen_in = curlen_e;
      pstart_in = pstart_e;
      mark_in   = mark_e;
      pstat_in  = pstat_e;
      rec_vld   = 1'b0;
      rec_avail = 32'd0;

      unique case (phase_e)
         PhCount, PhLen: begin
            if (wpos_e != 2'd3) begin
               case (wpos_e)
                  2'd0:    wbytes_in[7:0]   = data_byte;
                  2'd1:    wbytes_in[15:8]  = data_byte;
                  2'd2:    wbytes_in[23:16] = data_byte;
                  default: wbytes_in        = wbytes_e;
               endcase
               wpos_in = wpos_e + 2'd1;
            end else begin
               wbytes_in = 24'd0;
               wpos_in   = 2'd0;
               if (phase_e == PhCount) begin
                  if (count_bad || word != {24'd0, expected_count}) begin
                     phase_in = PhDone;
                     pstat_in = lpp_pkg::StatusMismatch;
                  end else begin
                     mark_in = nxt;
                     if (expected_count == 8'd0) begin
                        phase_in = PhDone;
                        pstat_in = lpp_pkg::StatusComplete;
                     end else begin
                        phase_in = PhLen;
                     end
                  end
               end else begin
                  mark_in   = nxt;
                  curlen_in = word;
                  left_in   = word;
                  pstart_in = nxt;
                  pdone_in  = pdone_e + 8'd1;
                  if (word == 32'd0) begin
                     rec_vld   = 1'b1;
                     rec_avail = 32'd0;
                     if (pdone_in >= expected_count) begin
                        phase_in = PhDone;
                        pstat_in = lpp_pkg::StatusComplete;
                     end else begin
                        phase_in = PhLen;
                     end
                  end else begin
                     phase_in = PhPayload;
                  end
               end
            end
         end
         PhPayload: begin
            left_in = left_e - 32'd1;
            mark_in = nxt;
            if (left_in == 32'd0) begin
               rec_vld   = 1'b1;
               rec_avail = curlen_e;
               if (pdone_e >= expected_count) begin
                  phase_in = PhDone;
                  pstat_in = lpp_pkg::StatusComplete;
               end else begin
                  phase_in = PhLen;
               end
            end
         end
         PhDone: begin
            // trailing bytes ignored
         end
         default: begin
         end
      endcase

      offset_in = nxt;

      // parameter cut short by the end of the buffer
      if (last_byte && phase_in == PhPayload) begin
         rec_vld   = 1'b1;
         rec_avail = curlen_in - left_in;
      end

      if (phase_in == PhCount)     sum_status = lpp_pkg::StatusCountShort;
      else if (phase_in == PhDone) sum_status = pstat_in;
      else                         sum_status = lpp_pkg::StatusTruncated;
      sum_ok = (expected_count == 8'd0) ||
               (phase_in == PhDone && pstat_in == lpp_pkg::StatusComplete);

      rec                  = '0;
      rec.final_res        = ~last_byte;
      rec.param_index      = pdone_in - 8'd1;
      rec.payload_offset   = pstart_in;
      rec.declared_length  = curlen_in;
      rec.available_length = (rec_avail > 32'h0000_FFFF) ? 16'hFFFF : rec_avail[15:0];

      sum                = '0;
      sum.is_summary     = 1'b1;
      sum.final_res      = 1'b1;
      sum.params_read    = pdone_in;
      sum.bytes_consumed = mark_in;
      sum.status         = sum_status;
      sum.ok             = sum_ok;

      // summary closes the buffer
      if (last_byte) begin
         phase_in  = PhCount;
         wpos_in   = 2'd0;
         wbytes_in = 24'd0;
         pdone_in  = 8'd0;
         left_in   = 32'd0;
         curlen_in = 32'd0;
         pstart_in = 16'd0;
         offset_in = 16'd0;
         mark_in   = 16'd0;
         pstat_in  = 2'd0;
      end

      push_a.valid = step && (rec_vld || last_byte);
      push_a.data  = rec_vld ? rec : sum;
      push_b.valid = step && rec_vld && last_byte;
      push_b.data  = sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PhCount;
         wpos_ff   <= 2'd0;
         wbytes_ff <= 24'd0;
         pdone_ff  <= 8'd0;
         left_ff   <= 32'd0;
         curlen_ff <= 32'd0;
         pstart_ff <= 16'd0;
         offset_ff <= 16'd0;
         mark_ff   <= 16'd0;
         pstat_ff  <= 2'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         wpos_ff   <= wpos_in;
         wbytes_ff <= wbytes_in;
         pdone_ff  <= pdone_in;
         left_ff   <= left_in;
         curlen_ff <= curlen_in;
         pstart_ff <= pstart_in;
         offset_ff <= offset_in;
         mark_ff   <= mark_in;
         pstat_ff  <= pstat_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/lpp_queue.sv
`default_nettype none

`include "length_prefixed_param_parser_top_defines.svh"

// Small result queue: up to two writes and one read per cycle.
module lpp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  lpp_pkg::lpp_push_type      push_a,
   input  lpp_pkg::lpp_push_type      push_b,
   output logic                       room,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output lpp_pkg::lpp_result_type    out_data
);

   lpp_pkg::lpp_result_type mem [lpp_pkg::QueueDepth];

   logic [lpp_pkg::QueueAddrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [lpp_pkg::QueueAddrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [lpp_pkg::QueueCountW-1:0] count_ff, count_in;
   logic [lpp_pkg::QueueAddrW-1:0]  wr_ptr_b;
   logic                            pop;

   assign pop       = out_valid && !out_stall;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   // two free slots needed for a worst-case byte
   assign room      = (count_ff <= lpp_pkg::QueueCountW'(lpp_pkg::QueueDepth - 2));
   assign wr_ptr_b  = wr_ptr_ff + lpp_pkg::QueueAddrW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + lpp_pkg::QueueAddrW'(push_a.valid)
                            + lpp_pkg::QueueAddrW'(push_b.valid);
      rd_ptr_in = rd_ptr_ff + lpp_pkg::QueueAddrW'(pop);
      count_in  = count_ff + lpp_pkg::QueueCountW'(push_a.valid)
                           + lpp_pkg::QueueCountW'(push_b.valid)
                           - lpp_pkg::QueueCountW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_a.valid) begin
         mem[wr_ptr_ff] <= push_a.data;
      end
      if (push_b.valid) begin
         mem[wr_ptr_b] <= push_b.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `LPP_ASSERT_ALWAYS(a_count_bound, count_ff <= lpp_pkg::QueueCountW'(lpp_pkg::QueueDepth), "result queue overflow")
   `LPP_ASSERT_ALWAYS(a_second_needs_first, !push_b.valid || push_a.valid, "second push without first")
   `LPP_ASSERT_NEXT(a_pop_drains, pop && !push_a.valid, count_ff == $past(count_ff) - lpp_pkg::QueueCountW'(1), "queue count did not drop on pop")
   `LPP_ASSERT_ALWAYS(a_ptr_gap, wr_ptr_ff == rd_ptr_ff + lpp_pkg::QueueAddrW'(count_ff), "queue pointers disagree with count")

endmodule

`default_nettype wire

FILE: bench/tb_length_prefixed_param_parser_top.sv
`default_nettype none

module tb_length_prefixed_param_parser_top;

   // Run knobs
   localparam int RequestsPerPhase = 135;   // random requests per expected_count setting
   localparam int HoldOffCycles    = 64;    // long receiver stall to back up the block
   localparam int SettleCycles     = 16;    // quiet time before a register write / the end
   localparam int QuietLimit       = 4000;  // cycles with no handshake before giving up

   // Parser position within the command buffer
   typedef enum logic [2:0] {
      PhCount,
      PhLength,
      PhPayload,
      PhDone
   } parse_phase_type;

   typedef logic [7:0] byte_q_type[$];

   // Expected-result tracker: mirrors the parser state and queues the
   // records and summaries each accepted request should produce.
   class param_parser_scoreboard;
      lpp_pkg::lpp_result_type expected_q[$];
      int unsigned     errors;
      logic [7:0]      expected_count;
      parse_phase_type phase;
      logic [1:0]      word_pos;
      logic [23:0]     word_acc;
      logic [7:0]      params_done;
      logic [31:0]     payload_left;
      logic [31:0]     current_length;
      logic [15:0]     payload_start;
      logic [15:0]     byte_offset;
      logic [15:0]     consumed_mark;
      logic [1:0]      parse_status;

      function new();
         errors = 0;
         expected_count = 8'd0;
         clear_buffer();
      endfunction

      function void clear_buffer();
         phase = PhCount;
         word_pos = '0;
         word_acc = '0;
         params_done = '0;
         payload_left = '0;
         current_length = '0;
         payload_start = '0;
         byte_offset = '0;
         consumed_mark = '0;
         parse_status = lpp_pkg::StatusComplete;
      endfunction

      function void set_count(logic [7:0] value);
         expected_count = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function lpp_pkg::lpp_result_type make_record(logic [31:0] avail);
         lpp_pkg::lpp_result_type rec;
         rec = '0;
         rec.param_index = params_done - 8'd1;
         rec.payload_offset = payload_start;
         rec.declared_length = current_length;
         rec.available_length = (avail > 32'hFFFF) ? 16'hFFFF : avail[15:0];
         return rec;
      endfunction

      function void close_param();
         if (params_done >= expected_count) begin
            phase = PhDone;
            parse_status = lpp_pkg::StatusComplete;
         end else begin
            phase = PhLength;
         end
      endfunction

      function void note_request(logic [7:0] data, logic first, logic last);
         lpp_pkg::lpp_result_type step_q[$];
         lpp_pkg::lpp_result_type summary;
         logic [15:0]             next_offset;
         logic [31:0]             word;
         if (first) clear_buffer();
         next_offset = (byte_offset < lpp_pkg::OffsetCapW) ? byte_offset + 16'd1
                                                           : lpp_pkg::OffsetCapW;

         if (phase == PhCount || phase == PhLength) begin
            if (word_pos != 2'd3) begin
               word_acc[8*word_pos +: 8] = data;
               word_pos++;
            end else begin
               word = {data, word_acc};
               word_acc = '0;
               word_pos = '0;
               if (phase == PhCount) begin
                  if (int'(expected_count) > lpp_pkg::MaxParams ||
                      word != 32'(expected_count)) begin
                     phase = PhDone;
                     parse_status = lpp_pkg::StatusMismatch;
                  end else begin
                     consumed_mark = next_offset;
                     if (expected_count == 8'd0) begin
                        phase = PhDone;
                        parse_status = lpp_pkg::StatusComplete;
                     end else begin
                        phase = PhLength;
                     end
                  end
               end else begin
                  consumed_mark = next_offset;
                  current_length = word;
                  payload_left = word;
                  payload_start = next_offset;
                  params_done++;
                  // zero-length parameter reports as soon as its length is in
                  if (word == 32'd0) begin
                     step_q.push_back(make_record(32'd0));
                     close_param();
                  end else begin
                     phase = PhPayload;
                  end
               end
            end
         end else if (phase == PhPayload) begin
            payload_left--;
            consumed_mark = next_offset;
            if (payload_left == 32'd0) begin
               step_q.push_back(make_record(current_length));
               close_param();
            end
         end
         byte_offset = next_offset;

         if (last) begin
            // a parameter cut off by the end of the buffer reports what arrived
            if (phase == PhPayload) step_q.push_back(make_record(current_length - payload_left));
            summary = '0;
            summary.is_summary = 1'b1;
            summary.params_read = params_done;
            summary.bytes_consumed = consumed_mark;
            if (phase == PhCount) summary.status = lpp_pkg::StatusCountShort;
            else if (phase == PhDone) summary.status = parse_status;
            else summary.status = lpp_pkg::StatusTruncated;
            summary.ok = (expected_count == 8'd0) ||
                         (phase == PhDone && parse_status == lpp_pkg::StatusComplete);
            step_q.push_back(summary);
            clear_buffer();
         end

         if (step_q.size() > 0) step_q[step_q.size()-1].final_res = 1'b1;
         foreach (step_q[i]) expected_q.push_back(step_q[i]);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(lpp_pkg::lpp_result_type got);
         lpp_pkg::lpp_result_type want;
         if (expected_q.size() == 0) begin
            $error("response with nothing expected (is_summary=%0d)", got.is_summary);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("is_summary", 32'(want.is_summary), 32'(got.is_summary));
         compare_field("final_res", 32'(want.final_res), 32'(got.final_res));
         compare_field("param_index", 32'(want.param_index), 32'(got.param_index));
         compare_field("payload_offset", 32'(want.payload_offset), 32'(got.payload_offset));
         compare_field("declared_length", want.declared_length, got.declared_length);
         compare_field("available_length", 32'(want.available_length),
                       32'(got.available_length));
         compare_field("params_read", 32'(want.params_read), 32'(got.params_read));
         compare_field("bytes_consumed", 32'(want.bytes_consumed), 32'(got.bytes_consumed));
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("ok", 32'(want.ok), 32'(got.ok));
      endfunction
   endclass

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // DUT ports; every input starts at a known value
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_summary;
   logic        rsp_final_res;
   logic [7:0]  rsp_param_index;
   logic [15:0] rsp_payload_offset;
   logic [31:0] rsp_declared_length;
   logic [15:0] rsp_available_length;
   logic [7:0]  rsp_params_read;
   logic [15:0] rsp_bytes_consumed;
   logic [1:0]  rsp_status;
   logic        rsp_ok;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_expected_count = 8'd0;

   lpp_pkg::lpp_result_type rsp_seen;
   assign rsp_seen = {rsp_is_summary, rsp_final_res, rsp_param_index, rsp_payload_offset,
                      rsp_declared_length, rsp_available_length, rsp_params_read,
                      rsp_bytes_consumed, rsp_status, rsp_ok};

   length_prefixed_param_parser_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_first_byte       (req_first_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_is_summary       (rsp_is_summary),
      .rsp_final_res        (rsp_final_res),
      .rsp_param_index      (rsp_param_index),
      .rsp_payload_offset   (rsp_payload_offset),
      .rsp_declared_length  (rsp_declared_length),
      .rsp_available_length (rsp_available_length),
      .rsp_params_read      (rsp_params_read),
      .rsp_bytes_consumed   (rsp_bytes_consumed),
      .rsp_status           (rsp_status),
      .rsp_ok               (rsp_ok),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_expected_count   (csr_expected_count)
   );

   param_parser_scoreboard sb = new();

   bit          calm = 1'b0;            // no idling on either side once set
   bit          hold_off_armed = 1'b0;  // receiver picks this up and stalls for a long stretch
   int unsigned requests_sent = 0;
   int unsigned quiet_cycles = 0;

   // Monitor: everything is sampled at the rising edge, before any NBA
   // update lands, so the request, register write and result seen here are
   // exactly the ones the DUT takes at this edge. Requests are noted before
   // results are checked; a result can never stem from the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_data_byte, req_first_byte, req_last_byte);
         if (csr_valid && csr_ready)
            sb.set_count(csr_expected_count);
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_seen);
      end
   end

   // Watchdog: counts edges at which no handshake of any kind completes.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
         $display("FAIL length_prefixed_param_parser_top");
         $finish;
      end
   end

   // Receiver: random stall bursts, one long hold-off on request, and a
   // clean tail once calm is set.
   initial begin : receiver
      @(posedge clock);
      forever begin
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            rsp_stall <= 1'b1;
            // sender keeps offering, so the queue and input register fill
            // and req_stall must rise
            repeat (HoldOffCycles) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Offer one byte, optionally after an idle burst; returns at the edge
   // where it is taken. Valid is left high for the next call.
   task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_first_byte <= first;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_command(input byte_q_type bytes, input bit mark_first);
      foreach (bytes[i])
         send_byte(bytes[i], mark_first && i == 0, i == bytes.size() - 1);
   endtask

   // Short random byte run with stray restarts mixed in
   task automatic send_noise();
      int count;
      count = $urandom_range(1, 10);
      for (int i = 0; i < count; i++)
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, i == count - 1);
   endtask

   // Drop valid, wait for every expected result, then let the pipe go quiet;
   // requests that produce no result may still be in flight at that point.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_expected(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_expected_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void append_word(ref byte_q_type bytes, input logic [31:0] word);
      for (int k = 0; k < 4; k++) bytes.push_back(word[8*k +: 8]);
   endfunction

   // Mostly well-formed command: right count word, short parameters.
   // Some get a bad count, a huge length, a cut or trailing junk.
   function automatic byte_q_type make_command(input logic [7:0] want);
      byte_q_type  bytes;
      logic [31:0] count_word;
      logic [31:0] len;
      int          roll;
      int          n_params;
      int          n_bytes;
      bit          stop;
      roll = $urandom_range(0, 99);
      if (roll < 6) count_word = $urandom();
      else if (roll < 12) count_word = 32'(want) + 32'd1;
      else if (roll < 15) count_word = 32'(want) - 32'd1;
      else count_word = 32'(want);
      append_word(bytes, count_word);

      // large counts can't be filled here; those buffers end truncated
      n_params = (want > 8'd6) ? int'($urandom_range(0, 6)) : int'(want);
      stop = 1'b0;
      for (int i = 0; i < n_params && !stop; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) len = $urandom_range(0, 4);
         else if (roll < 85) len = $urandom_range(5, 16);
         else if (roll < 95) len = $urandom_range(17, 40);
         else len = $urandom();
         append_word(bytes, len);
         stop = (len > 32'd40);
         n_bytes = stop ? int'($urandom_range(0, 12)) : int'(len);
         for (int j = 0; j < n_bytes; j++) bytes.push_back(8'($urandom_range(0, 255)));
      end

      if ($urandom_range(0, 6) == 0) begin
         n_bytes = $urandom_range(1, bytes.size());
         bytes = bytes[0:n_bytes-1];
      end else if ($urandom_range(0, 6) == 0) begin
         n_bytes = $urandom_range(1, 6);
         for (int j = 0; j < n_bytes; j++) bytes.push_back(8'($urandom_range(0, 255)));
      end
      return bytes;
   endfunction

   logic [7:0] phase_counts[6] = '{8'd1, 8'd3, 8'd255, 8'd0, 8'd0, 8'd2};

   initial begin : stimulus
      int unsigned phase_base;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, expected_count still at its reset value of zero:
      // lone byte (count word short), matching zero count, and a mismatch
      // that still reports ok.
      send_command('{8'hA5}, 1'b1);
      send_command('{8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
      send_command('{8'h05, 8'h00, 8'h00, 8'h00}, 1'b1);
      settle();

      // Two parameters: zero-length one reports on its length word, the
      // last payload byte carries both a record and the summary.
      write_expected(8'd2);
      send_command('{8'h02, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h00,
                     8'h03, 8'h00, 8'h00, 8'h00,
                     8'hFF, 8'h00, 8'h80}, 1'b1);

      // Random phases, one expected_count each, extremes included
      phase_counts[4] = 8'($urandom_range(4, 254));
      foreach (phase_counts[p]) begin
         settle();
         write_expected(phase_counts[p]);
         calm = (p == $size(phase_counts) - 1);
         if (p == 1) hold_off_armed = 1'b1;
         phase_base = requests_sent;
         while (requests_sent - phase_base < RequestsPerPhase) begin
            if ($urandom_range(0, 9) == 0)
               send_noise();
            else
               send_command(make_command(phase_counts[p]), $urandom_range(0, 4) != 0);
         end
      end

      settle();
      if (sb.errors == 0)
         $display("PASS length_prefixed_param_parser_top");
      else
         $display("FAIL length_prefixed_param_parser_top");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
+incdir+src
src/lpp_pkg.sv
src/lpp_core.sv
src/lpp_queue.sv
src/length_prefixed_param_parser_top.sv
bench/tb_length_prefixed_param_parser_top.sv
